>>> design/page_allocator_refcount_rmap_assert.svh
// Assertion macros shared by the page allocator modules.
// Each macro expects clk and arst_n to exist in the module that uses it.
`ifndef PAGE_ALLOCATOR_REFCOUNT_RMAP_ASSERT_SVH
`define PAGE_ALLOCATOR_REFCOUNT_RMAP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PARL_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PARL_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/parl_pkg.sv
package parl_pkg;

	// Field widths of the two channels.
	localparam int PAGE_W  = 10;
	localparam int ADDR_W  = 32;
	localparam int COUNT_W = 8;
	localparam int FREE_W  = 11;

	// Reference count limits.
	localparam logic signed [COUNT_W-1:0] REF_MAX  = 8'sd127;
	localparam logic signed [COUNT_W-1:0] REF_ONE  = 8'sd1;
	localparam logic signed [COUNT_W-1:0] REF_ZERO = 8'sd0;

	// Operation codes carried in the input beat.
	typedef enum logic [2:0] {
		OP_ALLOC      = 3'd0,
		OP_FREE       = 3'd1,
		OP_INC_REF    = 3'd2,
		OP_GET_REF    = 3'd3,
		OP_INSERT_MAP = 3'd4,
		OP_REMOVE_MAP = 3'd5
	} op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_OOM      = 2'd1,
		STAT_BAD_PAGE = 2'd2,
		STAT_MAP_FULL = 2'd3
	} status_t;

	// Commands understood by the reverse-map unit.
	typedef enum logic [1:0] {
		MOP_CLEAR  = 2'd0,
		MOP_INSERT = 2'd1,
		MOP_REMOVE = 2'd2
	} map_op_t;

	typedef struct packed {
		logic [2:0]        operation;
		logic [PAGE_W-1:0] page;
		logic [ADDR_W-1:0] entry_addr;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]                status;
		logic [PAGE_W-1:0]         alloc_page;
		logic signed [COUNT_W-1:0] ref_count;
		logic [FREE_W-1:0]         free_pages;
	} out_beat_t;

	typedef struct packed {
		logic    start;
		map_op_t op;
	} map_cmd_t;

	typedef struct packed {
		logic ready;
		logic done;
		logic full;
	} map_sts_t;

endpackage

>>> design/parl_map_unit.sv
`include "page_allocator_refcount_rmap_assert.svh"

module parl_map_unit #(
	parameter int NUM_PAGES = 1024,
	parameter int SLOTS     = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  parl_pkg::map_cmd_t            cmd,
	input  logic [$clog2(NUM_PAGES)-1:0]  page,
	input  logic [parl_pkg::ADDR_W-1:0]   entry_addr,
	output parl_pkg::map_sts_t            sts
);

	localparam int DEPTH = NUM_PAGES * SLOTS;
	localparam int MAW   = $clog2(DEPTH);
	localparam int CW    = $clog2(SLOTS + 1);

	localparam logic [CW-1:0]  LAST_SLOT  = CW'(SLOTS - 1);
	localparam logic [CW-1:0]  END_SLOT   = CW'(SLOTS);
	localparam logic [MAW-1:0] LAST_ENTRY = MAW'(DEPTH - 1);

	typedef enum logic [4:0] {
		M_INIT  = 5'b00001,
		M_IDLE  = 5'b00010,
		M_CLEAR = 5'b00100,
		M_SCAN  = 5'b01000,
		M_FIN   = 5'b10000
	} mstate_t;

	mstate_t                      state_q;
	parl_pkg::map_op_t            op_q;
	logic [MAW-1:0]               init_q;
	logic [MAW-1:0]               base_q;
	logic [parl_pkg::ADDR_W-1:0]  addr_q;
	logic [CW-1:0]                idx_q;
	logic                         cmp_vld_s1;
	logic [CW-1:0]                cmp_idx_s1;
	logic [parl_pkg::ADDR_W-1:0]  rd_data_s1;
	logic                         present_q;
	logic                         found_q;
	logic [CW-1:0]                zidx_q;

	logic [parl_pkg::ADDR_W-1:0]  mem [DEPTH];
	logic                         we;
	logic [MAW-1:0]               waddr;
	logic [parl_pkg::ADDR_W-1:0]  wdata;
	logic [MAW-1:0]               raddr;
	logic                         hit;
	logic                         empty;

	// The one comparator: the slot just read against the address and against zero.
	assign hit   = (rd_data_s1 == addr_q);
	assign empty = (rd_data_s1 == '0);

	assign raddr = base_q + MAW'(idx_q);

	// Write port selection for the clearing pass, page clear, remove and insert.
	always_comb begin
		we    = 1'b0;
		waddr = init_q;
		wdata = '0;
		case (state_q)
			M_INIT: begin
				we = 1'b1;
			end
			M_CLEAR: begin
				we    = 1'b1;
				waddr = base_q + MAW'(idx_q);
			end
			M_SCAN: begin
				we    = cmp_vld_s1 && (op_q == parl_pkg::MOP_REMOVE) && hit;
				waddr = base_q + MAW'(cmp_idx_s1);
			end
			M_FIN: begin
				we    = (op_q == parl_pkg::MOP_INSERT) && !present_q && found_q;
				waddr = base_q + MAW'(zidx_q);
				wdata = addr_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Slot memory with a registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_s1 <= mem[raddr];
	end

	// Sequencer for the slot walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= M_INIT;
			op_q       <= parl_pkg::MOP_CLEAR;
			init_q     <= '0;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			present_q  <= 1'b0;
			found_q    <= 1'b0;
			zidx_q     <= '0;
		end else begin
			case (state_q)
				M_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == LAST_ENTRY) begin
						state_q <= M_IDLE;
					end
				end
				M_IDLE: begin
					if (cmd.start) begin
						op_q       <= cmd.op;
						idx_q      <= '0;
						cmp_vld_s1 <= 1'b0;
						present_q  <= 1'b0;
						found_q    <= 1'b0;
						state_q    <= (cmd.op == parl_pkg::MOP_CLEAR) ? M_CLEAR : M_SCAN;
					end
				end
				M_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_SLOT) begin
						state_q <= M_FIN;
					end
				end
				M_SCAN: begin
					// Issue the next read while the previous slot is compared.
					if (idx_q != END_SLOT) begin
						idx_q      <= idx_q + 1'b1;
						cmp_vld_s1 <= 1'b1;
					end else begin
						cmp_vld_s1 <= 1'b0;
					end
					if (cmp_vld_s1) begin
						if (hit) begin
							present_q <= 1'b1;
						end
						if (empty && !found_q) begin
							found_q <= 1'b1;
							zidx_q  <= cmp_idx_s1;
						end
						if (cmp_idx_s1 == LAST_SLOT) begin
							state_q <= M_FIN;
						end
					end
				end
				M_FIN: begin
					state_q <= M_IDLE;
				end
				default: begin
					state_q <= M_INIT;
				end
			endcase
		end
	end

	// Command operands and the index of the slot in the read register.
	always_ff @(posedge clk) begin
		if ((state_q == M_IDLE) && cmd.start) begin
			base_q <= MAW'(page) * MAW'(SLOTS);
			addr_q <= entry_addr;
		end
		cmp_idx_s1 <= idx_q;
	end

	assign sts.ready = (state_q != M_INIT);
	assign sts.done  = (state_q == M_FIN);
	assign sts.full  = (state_q == M_FIN) && (op_q == parl_pkg::MOP_INSERT)
		&& !present_q && !found_q;

	`PARL_ASSERT_IMP(a_start_when_idle, cmd.start, state_q == M_IDLE, "map command while busy")
	`PARL_ASSERT_IMP(a_scan_write_remove, (state_q == M_SCAN) && we, op_q == parl_pkg::MOP_REMOVE, "scan write outside remove")

endmodule

>>> design/page_allocator_refcount_rmap.sv
// Physical page allocator with a LIFO free list, per-page reference counts and SLOTS
// reverse-map entries per page. After reset the block runs a clearing pass over the
// slot memory (the count memory is cleared in parallel) and accepts no beat until it
// ends. Then one beat is handled at a time: free, inc_ref, get_ref, a rejected page
// and an empty-list alloc pass through the read, execute and finish states; alloc,
// insert_map and remove_map also wait in the map state for the walk over the page's
// slots through the slot memory and its one comparator. A finished result sits in the
// output register, so the next beat is taken while it waits.
`include "page_allocator_refcount_rmap_assert.svh"

module page_allocator_refcount_rmap #(
	parameter int NUM_PAGES = 1024,
	parameter int SLOTS     = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  parl_pkg::in_beat_t            in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output parl_pkg::out_beat_t           out_data,
	input  logic                          cfg_wr_en,
	input  logic [parl_pkg::PAGE_W-1:0]   cfg_wr_data
);

	localparam int PW  = $clog2(NUM_PAGES);
	localparam int FCW = $clog2(NUM_PAGES + 1);

	localparam logic [PW-1:0]  LAST_PAGE = PW'(NUM_PAGES - 1);
	localparam logic [FCW-1:0] MAX_FREE  = FCW'(NUM_PAGES);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_READ  = 6'b000100,
		ST_EXEC  = 6'b001000,
		ST_MAP   = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t                            state_q;
	state_t                            state_d;
	logic [parl_pkg::PAGE_W-1:0]       lowest_q;
	logic [2:0]                        op_q;
	logic [parl_pkg::PAGE_W-1:0]       page_q;
	logic [parl_pkg::ADDR_W-1:0]       addr_q;
	logic [PW-1:0]                     head_q;
	logic [PW-1:0]                     head_d;
	logic                              head_vld_q;
	logic                              head_vld_d;
	logic [FCW-1:0]                    free_cnt_q;
	logic [FCW-1:0]                    free_cnt_d;
	logic [PW-1:0]                     clr_q;
	logic                              clr_done_q;
	parl_pkg::out_beat_t               res_q;
	parl_pkg::out_beat_t               res_d;
	parl_pkg::out_beat_t               out_data_q;
	logic                              out_valid_q;

	logic signed [parl_pkg::COUNT_W-1:0] ref_mem [NUM_PAGES];
	logic [PW:0]                         next_mem [NUM_PAGES];
	logic signed [parl_pkg::COUNT_W-1:0] ref_rd_q;
	logic [PW:0]                         next_rd_q;

	logic                                ref_we;
	logic [PW-1:0]                       ref_waddr;
	logic signed [parl_pkg::COUNT_W-1:0] ref_wdata;
	logic [PW-1:0]                       ref_raddr;
	logic                                next_we;
	logic [PW:0]                         next_wdata;
	logic [PW-1:0]                       pidx;
	logic                                bad_page;
	logic                                accept;
	logic                                fin_go;

	parl_pkg::map_cmd_t                  map_cmd;
	parl_pkg::map_sts_t                  map_sts;
	logic [PW-1:0]                       map_page;

	assign pidx      = PW'(page_q);
	assign ref_raddr = (op_q == parl_pkg::OP_ALLOC) ? head_q : pidx;
	assign bad_page  = (32'(page_q) >= 32'(NUM_PAGES))
		|| ((op_q == parl_pkg::OP_FREE) && (page_q < lowest_q));
	assign accept    = (state_q == ST_IDLE) && in_valid;
	assign fin_go    = !out_valid_q || !out_stall;

	// Operation sequencer and the update of the list, the counts and the result.
	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		head_vld_d  = head_vld_q;
		free_cnt_d  = free_cnt_q;
		res_d       = res_q;
		ref_we      = 1'b0;
		ref_waddr   = clr_q;
		ref_wdata   = parl_pkg::REF_ZERO;
		next_we     = 1'b0;
		next_wdata  = {head_vld_q, head_q};
		map_cmd.start = 1'b0;
		map_cmd.op    = parl_pkg::MOP_CLEAR;
		map_page    = pidx;
		case (state_q)
			ST_CLEAR: begin
				ref_we = !clr_done_q;
				if (clr_done_q && map_sts.ready) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				res_d.status     = parl_pkg::STAT_OK;
				res_d.alloc_page = '0;
				res_d.ref_count  = parl_pkg::REF_ZERO;
				if (op_q == parl_pkg::OP_ALLOC) begin
					if (!head_vld_q) begin
						res_d.status = parl_pkg::STAT_OOM;
					end else begin
						// Pop the head and give the page a single reference.
						head_d           = next_rd_q[PW-1:0];
						head_vld_d       = next_rd_q[PW];
						if (free_cnt_q != '0) begin
							free_cnt_d = free_cnt_q - 1'b1;
						end
						ref_we           = 1'b1;
						ref_waddr        = head_q;
						ref_wdata        = parl_pkg::REF_ONE;
						res_d.alloc_page = parl_pkg::PAGE_W'(head_q);
						res_d.ref_count  = parl_pkg::REF_ONE;
						map_cmd.start    = 1'b1;
						map_cmd.op       = parl_pkg::MOP_CLEAR;
						map_page         = head_q;
					end
				end else if (op_q > parl_pkg::OP_REMOVE_MAP) begin
					res_d.status = parl_pkg::STAT_OK;
				end else if (bad_page) begin
					res_d.status = parl_pkg::STAT_BAD_PAGE;
				end else begin
					res_d.ref_count = ref_rd_q;
					case (op_q)
						parl_pkg::OP_FREE: begin
							ref_we    = 1'b1;
							ref_waddr = pidx;
							if (ref_rd_q > parl_pkg::REF_ONE) begin
								ref_wdata       = ref_rd_q - parl_pkg::REF_ONE;
								res_d.ref_count = ref_rd_q - parl_pkg::REF_ONE;
							end else begin
								// Last reference gone: push the page on the list.
								ref_wdata       = parl_pkg::REF_ZERO;
								res_d.ref_count = parl_pkg::REF_ZERO;
								next_we         = 1'b1;
								head_d          = pidx;
								head_vld_d      = 1'b1;
								if (free_cnt_q < MAX_FREE) begin
									free_cnt_d = free_cnt_q + 1'b1;
								end
							end
						end
						parl_pkg::OP_INC_REF: begin
							if (ref_rd_q < parl_pkg::REF_MAX) begin
								ref_we          = 1'b1;
								ref_waddr       = pidx;
								ref_wdata       = ref_rd_q + parl_pkg::REF_ONE;
								res_d.ref_count = ref_rd_q + parl_pkg::REF_ONE;
							end
						end
						parl_pkg::OP_INSERT_MAP: begin
							map_cmd.start = 1'b1;
							map_cmd.op    = parl_pkg::MOP_INSERT;
						end
						parl_pkg::OP_REMOVE_MAP: begin
							map_cmd.start = 1'b1;
							map_cmd.op    = parl_pkg::MOP_REMOVE;
						end
						default: begin
							res_d.ref_count = ref_rd_q;
						end
					endcase
				end
				res_d.free_pages = parl_pkg::FREE_W'(free_cnt_d);
				state_d = map_cmd.start ? ST_MAP : ST_FIN;
			end
			ST_MAP: begin
				if (map_sts.done) begin
					if (map_sts.full) begin
						res_d.status = parl_pkg::STAT_MAP_FULL;
					end
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// Count and link memories with registered reads.
	always_ff @(posedge clk) begin
		if (ref_we) begin
			ref_mem[ref_waddr] <= ref_wdata;
		end
		ref_rd_q <= ref_mem[ref_raddr];
		if (next_we) begin
			next_mem[pidx] <= next_wdata;
		end
		next_rd_q <= next_mem[head_q];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			lowest_q    <= '0;
			head_q      <= '0;
			head_vld_q  <= 1'b0;
			free_cnt_q  <= '0;
			clr_q       <= '0;
			clr_done_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			head_q     <= head_d;
			head_vld_q <= head_vld_d;
			free_cnt_q <= free_cnt_d;
			if (cfg_wr_en) begin
				lowest_q <= cfg_wr_data;
			end
			if ((state_q == ST_CLEAR) && !clr_done_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == LAST_PAGE) begin
					clr_done_q <= 1'b1;
				end
			end
			if ((state_q == ST_FIN) && fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Captured beat, working result and output register.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= in_data.operation;
			page_q <= in_data.page;
			addr_q <= in_data.entry_addr;
		end
		res_q <= res_d;
		if ((state_q == ST_FIN) && fin_go) begin
			out_data_q <= res_q;
		end
	end

	parl_map_unit #(
		.NUM_PAGES (NUM_PAGES),
		.SLOTS     (SLOTS)
	) u_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (map_cmd),
		.page       (map_page),
		.entry_addr (addr_q),
		.sts        (map_sts)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`PARL_ASSERT_IMP(a_done_in_map, map_sts.done, state_q == ST_MAP, "map done outside wait state")
	`PARL_ASSERT_NXT(a_start_to_map, map_cmd.start, state_q == ST_MAP, "map start without wait state")
	`PARL_ASSERT_NXT(a_alloc_count, (state_q == ST_EXEC) && (op_q == parl_pkg::OP_ALLOC) && head_vld_q, (res_q.ref_count == parl_pkg::REF_ONE) && (res_q.status == parl_pkg::STAT_OK), "alloc result wrong")

endmodule
